// ===== rtl/nca_pkg.sv =====
// ----------------------------------------------------------------------------
// nca_pkg
// Shared types and constants for the nearest-centroid assignment block:
// payload structs, opcodes, accumulator control and the scan candidate.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int DEF_MAX_CLONES  = 16;
    localparam int DEF_MAX_SAMPLES = 16;

    localparam int VAL_W   = 16;
    localparam int SQ_W    = 2 * VAL_W;
    localparam int ACC_W   = 35;
    localparam int TOT_W   = 50;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 6;
    localparam int CLONE_W = 4;
    localparam int SIDX_W  = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    localparam logic [CFG_W-1:0] CLONES_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } nca_op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [CLONE_W-1:0] clone_index;
        logic [SIDX_W-1:0]  sample_index;
        logic [VAL_W-1:0]   value;
        logic               last_sample;
    } nca_in_t;

    typedef struct packed {
        logic [CLONE_W-1:0] assigned_clone;
        logic [ACC_W-1:0]   vector_error;
        logic [TOT_W-1:0]   total_error;
    } nca_out_t;

    typedef struct packed {
        logic add;
        logic clr;
    } nca_acc_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] err;
    } nca_cand_t;

endpackage

// ===== rtl/nca_ram.sv =====
// ----------------------------------------------------------------------------
// nca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nca_cell.sv =====
// ----------------------------------------------------------------------------
// nca_cell
// One clone: its centroid column, squared-difference accumulator and one
// step of the minimum scan handed along the chain.
// ----------------------------------------------------------------------------
module nca_cell #(
    parameter int MAX_CLONES  = 16,
    parameter int MAX_SAMPLES = 16,
    parameter int K           = 0,
    parameter int SAW         = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int CW          = $clog2(MAX_CLONES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [SAW-1:0]           wr_addr,
    input  logic [nca_pkg::VAL_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [SAW-1:0]           rd_addr,
    input  logic [nca_pkg::VAL_W-1:0] value_s1,
    input  nca_pkg::nca_acc_ctl_t    acc_ctl,
    input  logic [CW-1:0]            n_active,
    input  nca_pkg::nca_cand_t       scan_in,
    output nca_pkg::nca_cand_t       scan_out
);

    import nca_pkg::*;

    logic [VAL_W-1:0] cent;
    logic [VAL_W-1:0] diff;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W:0]   acc_sum;
    logic             active;
    logic             take;
    nca_cand_t        scan_reg, scan_next;

    nca_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SAMPLES),
        .AW    (SAW)
    ) u_col (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cent)
    );

    // squared difference against this clone's centroid value
    always_comb begin
        diff    = (value_s1 >= cent) ? (value_s1 - cent) : (cent - value_s1);
        sq_next = SQ_W'(diff) * SQ_W'(diff);
    end

    always_ff @(posedge aclk) begin
        sq_reg <= sq_next;
    end

    // saturating accumulate, cleared by opcode or once the scan passes
    always_comb begin
        acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(sq_reg);
        priority if (acc_ctl.clr) begin
            acc_next = '0;
        end else if (acc_ctl.add) begin
            acc_next = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        end else if (scan_in.valid) begin
            acc_next = '0;
        end else begin
            acc_next = acc_reg;
        end
    end

    // strict compare keeps the lowest index on a tie
    always_comb begin
        active    = CW'(K) < n_active;
        take      = scan_in.valid && active && (acc_reg < scan_in.err);
        scan_next = scan_in;
        if (take) begin
            scan_next.idx = IDX_W'(K);
            scan_next.err = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            scan_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

// ===== rtl/nearest_centroid_assign_top.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top
// Nearest-centroid assignment: per-clone squared error accumulation over a
// streamed vector, then the least-error clone and a saturating total.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per transfer; opcode selects centroid write, vector
//   sample, clear or nop; each is taken one per cycle while s_ready is high.
//   m_ channel: one result per vector, after the sample marked last_sample.
//   cfg channel: clones_in_use, always ready; the user must write it while the
//   block idles, as the block itself does not enforce this.
// result path
//   the last-sample transfer passes s1_last_reg, s2_last_reg and start_reg,
//   then the minimum scan walks the row of clone cells one cell per cycle,
//   and the result moves through the holding and output registers.
//   s_ready stays low from the last-sample transfer until the result moves
//   into the output register, so the next item waits until then.
// reset
//   accumulators and total clear, clones_in_use returns to 16, centroid
//   table holds garbage until written.
// stall
//   a stalled result waits in the output register with one result behind it
//   in a holding register; new items are taken once that holding slot drains.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top #(
    parameter int MAX_CLONES  = nca_pkg::DEF_MAX_CLONES,
    parameter int MAX_SAMPLES = nca_pkg::DEF_MAX_SAMPLES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  nca_pkg::nca_in_t          s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output nca_pkg::nca_out_t         m_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [nca_pkg::CFG_W-1:0] cfg_data
);

    import nca_pkg::*;

    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = $clog2(MAX_CLONES + 1);

    logic             s_xfer;
    logic             m_xfer;
    logic             is_write, is_sample, is_clear;
    logic             s_in_range, c_in_range;
    logic [SAW-1:0]   saddr;
    logic [CW-1:0]    n_active;

    logic [CFG_W-1:0] clones_reg;
    logic             busy_reg, busy_next;

    logic             s1_add_reg, s1_clr_reg, s1_last_reg;
    logic [VAL_W-1:0] s1_value_reg;
    logic             s2_add_reg, s2_clr_reg, s2_last_reg;
    logic             start_reg;
    nca_acc_ctl_t     acc_ctl;

    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W:0]   tot_sum;

    logic             pend_valid_reg, pend_valid_next;
    nca_out_t         pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    nca_out_t         m_item_reg, m_item_next;

    nca_cand_t        chain [MAX_CLONES+1];

    assign s_ready   = !busy_reg;
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        is_write   = s_xfer && (s_item.opcode == OP_WRITE);
        is_sample  = s_xfer && (s_item.opcode == OP_SAMPLE);
        is_clear   = s_xfer && (s_item.opcode == OP_CLEAR);
        s_in_range = int'(s_item.sample_index) < MAX_SAMPLES;
        c_in_range = int'(s_item.clone_index) < MAX_CLONES;
        saddr      = SAW'(s_item.sample_index);
    end

    // effective clone count
    always_comb begin
        priority if (clones_reg == '0) begin
            n_active = CW'(1);
        end else if (int'(clones_reg) > MAX_CLONES) begin
            n_active = CW'(MAX_CLONES);
        end else begin
            n_active = CW'(clones_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clones_reg <= CLONES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            clones_reg <= cfg_data;
        end
    end

    // sample pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_add_reg  <= 1'b0;
            s1_clr_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_add_reg  <= 1'b0;
            s2_clr_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            start_reg   <= 1'b0;
        end else begin
            s1_add_reg  <= is_sample && s_in_range;
            s1_clr_reg  <= is_clear;
            s1_last_reg <= is_sample && s_item.last_sample;
            s2_add_reg  <= s1_add_reg;
            s2_clr_reg  <= s1_clr_reg;
            s2_last_reg <= s1_last_reg;
            start_reg   <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_value_reg <= s_item.value;
    end

    assign acc_ctl.add = s2_add_reg;
    assign acc_ctl.clr = s2_clr_reg;

    // scan enters at clone 0 with an error that any real error ties or beats
    always_comb begin
        chain[0].valid = start_reg;
        chain[0].idx   = '0;
        chain[0].err   = ACC_MAX;
    end

    for (genvar k = 0; k < MAX_CLONES; k++) begin : g_cell
        nca_cell #(
            .MAX_CLONES  (MAX_CLONES),
            .MAX_SAMPLES (MAX_SAMPLES),
            .K           (k),
            .SAW         (SAW),
            .CW          (CW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (is_write && s_in_range && c_in_range
                       && (int'(s_item.clone_index) == k)),
            .wr_addr  (saddr),
            .wr_data  (s_item.value),
            .rd_en    (is_sample),
            .rd_addr  (saddr),
            .value_s1 (s1_value_reg),
            .acc_ctl  (acc_ctl),
            .n_active (n_active),
            .scan_in  (chain[k]),
            .scan_out (chain[k+1])
        );
    end

    // running total, holding slot and output register
    always_comb begin
        tot_sum         = {1'b0, total_reg} + (TOT_W + 1)'(chain[MAX_CLONES].err);
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        busy_next       = busy_reg;

        if (is_clear) begin
            total_next = '0;
        end
        if (is_sample && s_item.last_sample) begin
            busy_next = 1'b1;
        end

        if (m_xfer) begin
            m_valid_next = 1'b0;
        end
        if (pend_valid_reg && (!m_valid_reg || m_ready)) begin
            m_valid_next    = 1'b1;
            m_item_next     = pend_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (chain[MAX_CLONES].valid) begin
            total_next               = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
            pend_valid_next          = 1'b1;
            pend_next.assigned_clone = CLONE_W'(chain[MAX_CLONES].idx);
            pend_next.vector_error   = chain[MAX_CLONES].err;
            pend_next.total_error    = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            busy_reg       <= 1'b0;
        end else begin
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> busy_reg)
        else $error("result pending while input open");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_CLONES].valid |-> !pend_valid_reg)
        else $error("scan result overwrites pending result");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> busy_reg)
        else $error("scan started while input open");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_sample && s_item.last_sample) |=> !s_ready)
        else $error("input still open after last sample transfer");

endmodule
